>>> hdl/pwtm_pkg.sv
// ----------------------------------------------------------------------------
// pwtm_pkg
// Types, constants and the control store of the trimmed-mean pH block.
// ----------------------------------------------------------------------------
package pwtm_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int SAMPLE_MAX  = 1023;
  localparam int SLOPE_W     = 13;
  localparam int OFFSET_W    = 12;
  localparam int Q6_W        = 16;
  localparam int PH_W        = 17;
  localparam int Q_FRAC      = 6;
  localparam int SCALE_SHIFT = 10;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int STEP_W      = 3;

  localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 13'd3500;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd0;

  localparam logic REG_SLOPE  = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_SCAN  = 3'd1;
  localparam step_t STEP_DRAIN = 3'd2;
  localparam step_t STEP_TRIM  = 3'd3;
  localparam step_t STEP_MUL   = 3'd4;
  localparam step_t STEP_SCALE = 3'd5;
  localparam step_t STEP_DIV   = 3'd6;
  localparam step_t STEP_OUT   = 3'd7;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_NO_INPUT  = 3'd1,
    COND_SCAN_MORE = 3'd2,
    COND_OUT_BUSY  = 3'd4
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  mem_rd;
    logic  trim_ld;
    logic  mul_ld;
    logic  scale_ld;
    logic  div_step;
    logic  out_ld;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  // The step after the last one wraps to the idle step.
  function automatic ctl_word_t ucode(input step_t s);
    ctl_word_t w;
    w = '{take_in: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0, mem_rd: 1'b0,
          trim_ld: 1'b0, mul_ld: 1'b0, scale_ld: 1'b0, div_step: 1'b0,
          out_ld: 1'b0, cond: COND_NEVER, target: STEP_IDLE};
    unique case (s)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cnt_clr = 1'b1;
        w.cond    = COND_NO_INPUT;
        w.target  = STEP_IDLE;
      end
      STEP_SCAN: begin
        w.cnt_inc = 1'b1;
        w.mem_rd  = 1'b1;
        w.cond    = COND_SCAN_MORE;
        w.target  = STEP_SCAN;
      end
      STEP_DRAIN: begin
        w.cond = COND_NEVER;
      end
      STEP_TRIM: begin
        w.trim_ld = 1'b1;
      end
      STEP_MUL: begin
        w.mul_ld  = 1'b1;
        w.cnt_clr = 1'b1;
      end
      STEP_SCALE: begin
        w.scale_ld = 1'b1;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
      end
      STEP_OUT: begin
        w.out_ld = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_OUT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/pwtm_ram.sv
// ----------------------------------------------------------------------------
// pwtm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pwtm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ph_window_trimmed_mean.sv
// ----------------------------------------------------------------------------
// ph_window_trimmed_mean
// Moving-window trimmed mean of pH converter samples and conversion to pH.
// ----------------------------------------------------------------------------
// Each accepted sample overwrites the oldest entry of a WINDOW-deep ring that
// reads as zero until written. A small control program then scans the ring
// through the single read port of its RAM, one entry per cycle, drops one
// minimum and one maximum, and divides both results by WINDOW-2 with one
// multiplication by a fixed reciprocal each. The result is loaded once the
// output register is free, and the next sample is accepted only after that,
// when the control program is back in its idle step. A new sample
// is accepted while the previous result still waits in the output register.
module ph_window_trimmed_mean #(
  parameter int WINDOW = 40
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pwtm_pkg::SAMPLE_W-1:0] sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pwtm_pkg::Q6_W-1:0]    trimmed_mean_q6,
  output logic [pwtm_pkg::PH_W-1:0]    ph_milli,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pwtm_pkg::ADDR_W-1:0]  paddr,
  input  logic [pwtm_pkg::DATA_W-1:0]  pwdata,
  output logic [pwtm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  import pwtm_pkg::*;

  localparam int AW      = $clog2(WINDOW);
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int SUM_W   = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int NW      = SUM_W + Q_FRAC;
  localparam int PROD_W  = SUM_W + SLOPE_W;
  localparam int P5_W    = PROD_W + 3;
  localparam int DIVISOR = WINDOW - 2;
  localparam int DIV_L   = $clog2(DIVISOR);
  localparam int DIV_S   = NW + DIV_L;
  localparam int RECIP_W = NW + 1;
  localparam int QP_W    = NW + RECIP_W;
  localparam longint unsigned RECIP =
      ((64'd1 << DIV_S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int CNT_W   = $clog2(WINDOW);
  localparam int CMP_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  step_t             step;
  step_t             step_next;
  ctl_word_t         word;
  logic              jump;
  logic              accept;
  logic              out_busy;
  logic              cfg_write;

  logic [CNT_W-1:0]  cnt;
  logic [AW-1:0]     wr_ptr;
  logic [FILL_W-1:0] fill;
  logic              rd_vld;
  logic              rd_ok;
  logic [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0] v;

  logic [SUM_W-1:0]  sum;
  logic [SAMPLE_W-1:0] mn;
  logic [SAMPLE_W-1:0] mx;
  logic [SUM_W-1:0]  trim;
  logic [PROD_W-1:0] prod;
  logic [P5_W-1:0]   p5;

  logic [NW-1:0]     numa;
  logic [NW-1:0]     numb;
  logic [QP_W-1:0]   qa;
  logic [QP_W-1:0]   qb;

  logic [SLOPE_W-1:0]  slope;
  logic [OFFSET_W-1:0] offset;

  assign word     = ucode(step);
  assign in_ready = word.take_in;
  assign accept   = in_valid & word.take_in;
  assign out_busy = out_valid & ~out_ready;

  always_comb begin
    unique case (word.cond)
      COND_NEVER:     jump = 1'b0;
      COND_NO_INPUT:  jump = ~in_valid;
      COND_SCAN_MORE: jump = (cnt != CNT_W'(WINDOW - 1));
      COND_OUT_BUSY:  jump = out_busy;
      default:        jump = 1'b0;
    endcase
    step_next = jump ? word.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (word.cnt_clr) begin
      cnt <= '0;
    end else if (word.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      fill   <= '0;
    end else if (accept) begin
      wr_ptr <= (wr_ptr == AW'(WINDOW - 1)) ? '0 : wr_ptr + 1'b1;
      if (fill != FILL_W'(WINDOW)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  pwtm_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (accept),
    .waddr(wr_ptr),
    .wdata(sample),
    .re   (word.mem_rd),
    .raddr(cnt[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      rd_ok  <= 1'b0;
    end else begin
      rd_vld <= word.mem_rd;
      rd_ok  <= (CMP_W'(cnt) < CMP_W'(fill));
    end
  end

  assign v = rd_ok ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      sum <= '0;
      mn  <= SAMPLE_W'(SAMPLE_MAX);
      mx  <= '0;
    end else if (rd_vld) begin
      sum <= sum + SUM_W'(v);
      if (v < mn) begin
        mn <= v;
      end
      if (v > mx) begin
        mx <= v;
      end
    end
  end

  assign p5 = P5_W'({prod, 2'b00}) + P5_W'(prod);

  assign qa = QP_W'(numa) * QP_W'(RECIP);
  assign qb = QP_W'(numb) * QP_W'(RECIP);

  always_ff @(posedge clk) begin
    if (word.trim_ld) begin
      trim <= sum - SUM_W'(mn) - SUM_W'(mx);
    end
    if (word.mul_ld) begin
      prod <= PROD_W'(trim) * PROD_W'(slope);
      numa <= {trim, Q_FRAC'(0)};
    end
    if (word.scale_ld) begin
      numb <= p5[SCALE_SHIFT +: NW];
    end
    if (word.div_step) begin
      numa <= NW'(qa >> DIV_S);
      numb <= NW'(qb >> DIV_S);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (word.out_ld && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word.out_ld && !out_busy) begin
      trimmed_mean_q6 <= numa[Q6_W-1:0];
      ph_milli        <= numb[PH_W-1:0]
                         + {{(PH_W - OFFSET_W){offset[OFFSET_W-1]}}, offset};
    end
  end

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope  <= SLOPE_RESET;
      offset <= OFFSET_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SLOPE:  slope  <= pwdata[SLOPE_W-1:0];
        REG_OFFSET: offset <= pwdata[OFFSET_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SLOPE:  prdata = DATA_W'(slope);
      REG_OFFSET: prdata = {{(DATA_W - OFFSET_W){offset[OFFSET_W-1]}}, offset};
    endcase
  end

endmodule

>>> hdl/pwtm_chk.sv
// ----------------------------------------------------------------------------
// pwtm_chk
// Port-level checks of the trimmed-mean pH block, bound to its top level.
// ----------------------------------------------------------------------------
module pwtm_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pwtm_pkg::Q6_W-1:0]    trimmed_mean_q6,
  input logic [pwtm_pkg::PH_W-1:0]    ph_milli
);

  import pwtm_pkg::*;

  localparam logic [Q6_W-1:0] Q6_MAX = Q6_W'(SAMPLE_MAX * (1 << Q_FRAC));

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(trimmed_mean_q6)
                                && $stable(ph_milli))
    else $error("Result changed while its transaction was stalled.");

  a_q6_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> trimmed_mean_q6 <= Q6_MAX)
    else $error("Trimmed mean exceeds the largest sample value.");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted again directly after a transaction.");

  a_no_fast_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("Result appeared in the cycle after an input transaction.");

  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("Result appeared while the block was waiting for input.");

endmodule

bind ph_window_trimmed_mean pwtm_chk u_pwtm_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .trimmed_mean_q6(trimmed_mean_q6),
  .ph_milli       (ph_milli)
);

>>> tb/ph_window_trimmed_mean_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ph_window_trimmed_mean_tb
// Self-checking testbench for the trimmed-mean pH block.
// ----------------------------------------------------------------------------
// Samples are fed through the valid/ready input with random idle bursts, and
// a local model of the sample ring predicts the trimmed mean and pH of every
// accepted transaction. Results are compared in order, field by field. The
// run steps through several slope and offset settings over the APB port,
// each written while the block is drained.
// ----------------------------------------------------------------------------
module ph_window_trimmed_mean_tb;
  import pwtm_pkg::*;

  localparam int WINDOW     = 40;
  localparam int TRIM_DIV   = WINDOW - 2;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_LEN  = 285;
  localparam int LIMIT      = 1_000_000;

  localparam logic [ADDR_W-1:0] SLOPE_ADDR  = {REG_SLOPE, 2'b00};
  localparam logic [ADDR_W-1:0] OFFSET_ADDR = {REG_OFFSET, 2'b00};

  typedef struct packed {
    logic [Q6_W-1:0] mean_q6;
    logic [PH_W-1:0] ph;
  } reading_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [Q6_W-1:0]     trimmed_mean_q6;
  logic [PH_W-1:0]     ph_milli;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [SAMPLE_W-1:0]        ring_model [WINDOW] = '{default: '0};
  int                         ring_wr = 0;
  logic [SLOPE_W-1:0]         slope_cfg = SLOPE_RESET;
  logic signed [OFFSET_W-1:0] offset_cfg = OFFSET_RESET;

  logic [SAMPLE_W-1:0] sample_backlog [$];
  reading_t            expected_readings [$];
  int                  samples_queued = 0;
  int                  readings_seen = 0;
  int                  mismatches = 0;
  int                  cycles = 0;
  int                  in_gap = 0;
  int                  out_hold = 0;
  bit                  idle_en = 1'b1;

  ph_window_trimmed_mean #(.WINDOW(WINDOW)) u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] s);
    longint unsigned total;
    longint unsigned trimmed;
    longint unsigned scaled;
    longint          ph;
    int unsigned     lo;
    int unsigned     hi;
    reading_t        r;
    ring_model[ring_wr] = s;
    ring_wr = (ring_wr == WINDOW - 1) ? 0 : ring_wr + 1;
    total = 0;
    lo = SAMPLE_MAX;
    hi = 0;
    for (int i = 0; i < WINDOW; i++) begin
      total += ring_model[i];
      if (ring_model[i] < lo) lo = ring_model[i];
      if (ring_model[i] > hi) hi = ring_model[i];
    end
    trimmed = total - lo - hi;
    scaled = (trimmed * 5 * slope_cfg) / (1024 * TRIM_DIV);
    ph = longint'(scaled) + longint'(offset_cfg);
    r.mean_q6 = Q6_W'((trimmed * 64) / TRIM_DIV);
    r.ph = PH_W'(ph);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(predict_reading(sample));
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          in_valid <= 1'b1;
          sample <= sample_backlog.pop_front();
          if (idle_en && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          $error("unexpected result transaction: trimmed_mean_q6=%0d ph_milli=%0d",
                 trimmed_mean_q6, $signed(ph_milli));
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (trimmed_mean_q6 !== want.mean_q6) begin
            $error("trimmed_mean_q6: expected %0d, actual %0d", want.mean_q6,
                   trimmed_mean_q6);
            mismatches++;
          end
          if (ph_milli !== want.ph) begin
            $error("ph_milli: expected %0d, actual %0d", $signed(want.ph),
                   $signed(ph_milli));
            mismatches++;
          end
        end
      end
      if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_hold <= $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("ph_window_trimmed_mean verification failed");
      $finish;
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    sample_backlog.push_back(s);
    samples_queued++;
  endtask

  task automatic wait_drained();
    while (readings_seen < samples_queued) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_ph(input logic [SLOPE_W-1:0] slope,
                            input logic signed [OFFSET_W-1:0] offset);
    apb_write(SLOPE_ADDR, DATA_W'(slope));
    apb_write(OFFSET_ADDR, {{(DATA_W - OFFSET_W){offset[OFFSET_W-1]}}, offset});
    slope_cfg = slope;
    offset_cfg = offset;
  endtask

  // Runs of 0 or of the maximum fill the whole window, which exercises ties and
  // the extreme sums; other runs repeat one random value, and the rest are single random samples.
  task automatic queue_random(input int count);
    int                  left;
    int                  kind;
    int                  run;
    logic [SAMPLE_W-1:0] v;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        v = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
        run = $urandom_range(WINDOW, WINDOW + 6);
      end else if (kind == 1) begin
        v = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        run = $urandom_range(10, WINDOW + 5);
      end else begin
        v = '0;
        run = $urandom_range(1, 20);
      end
      if (run > left) run = left;
      for (int i = 0; i < run; i++) begin
        push_sample(kind > 1 ? SAMPLE_W'($urandom_range(0, SAMPLE_MAX)) : v);
      end
      left -= run;
    end
  endtask

  initial begin
    int slopes [NUM_PHASES];
    int offsets [NUM_PHASES];
    slopes = '{0, 8191, 8000, 1, 3500, 4096, 0};
    offsets = '{-2048, 2047, -2000, 2000, 0, -1, 0};
    slopes[NUM_PHASES-1] = $urandom_range(0, 8191);
    offsets[NUM_PHASES-1] = int'($urandom_range(0, 4095)) - 2048;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The ring starts at zero, so the first windows are full of ties.
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample('0);
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(10'h200);
    push_sample(10'h155);
    push_sample(10'h2AA);
    push_sample(10'h001);
    push_sample(10'h3FE);
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample('0);
    push_sample(10'h0FF);
    push_sample(10'h300);
    push_sample(SAMPLE_W'(SAMPLE_MAX));
    push_sample(10'h001);
    push_sample(10'h001);
    push_sample(10'h3FE);
    push_sample(10'h3FE);
    push_sample(10'h07F);
    push_sample(10'h380);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_ph(SLOPE_W'(slopes[p]), OFFSET_W'(offsets[p]));
      idle_en = (p != 3) && (p != NUM_PHASES - 1);
      queue_random(PHASE_LEN);
      wait_drained();
    end

    repeat (80) @(posedge clk);
    if (expected_readings.size() != 0) begin
      $error("%0d expected result transactions never arrived", expected_readings.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ph_window_trimmed_mean verification clean");
    end else begin
      $display("ph_window_trimmed_mean verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pwtm_pkg.sv
hdl/pwtm_ram.sv
hdl/ph_window_trimmed_mean.sv
hdl/pwtm_chk.sv
tb/ph_window_trimmed_mean_tb.sv
